/* rtl/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// shared constants for the point bearing angle block: default widths,
// turn constants of the angle accumulator and the cordic arctangent table
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;

    localparam int ACC_WIDTH = 32;
    localparam int TABLE_LEN = 24;

    typedef logic [ACC_WIDTH-1:0] acc_t;

    localparam acc_t TURN_ZERO    = 32'h0000_0000;
    localparam acc_t TURN_QUARTER = 32'h4000_0000;
    localparam acc_t TURN_HALF    = 32'h8000_0000;
    localparam acc_t TURN_3QUART  = 32'hC000_0000;

    // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
    localparam acc_t ATAN_TURNS [0:TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

/* rtl/point_bearing_angle.sv */
// ----------------------------------------------------------------------------
// point_bearing_angle
// direction from one point to another as an unsigned binary angle, computed
// by a fully unrolled cordic vectoring pipeline with atan2 quadrant handling
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: from_x, from_y, to_x, to_y
//  m_axis   | out       | tdata: bearing, tuser: same_point
//
//  one item per cycle while m_axis is not stalled; registers: difference stage,
//  one stage per cordic micro-rotation, rounding/output register
//  each stage advances when its successor is empty or advancing, so bubbles
//  are squeezed out while the output is stalled
//  rst_n clears the valid bits only; the data path carries no reset
// ----------------------------------------------------------------------------
module point_bearing_angle #(
    parameter int COORD_WIDTH = pba_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = pba_pkg::ANGLE_WIDTH_DEF,
    parameter int ITERATIONS  = pba_pkg::ITERATIONS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // from_x, from_y, to_x, to_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // bearing
    output logic [((ANGLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // same_point
    output logic                                   m_axis_tuser
);

    import pba_pkg::*;

    localparam int OUT_W  = ((ANGLE_WIDTH+7)/8)*8;
    localparam int XW     = COORD_WIDTH + 3;
    localparam acc_t ROUND_ADD = acc_t'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH);

    // stage k holds the vector after k micro-rotations
    logic signed [XW-1:0] x_reg    [0:ITERATIONS];
    logic signed [XW-1:0] y_reg    [0:ITERATIONS];
    acc_t                 acc_reg  [0:ITERATIONS];
    logic                 hold_reg [0:ITERATIONS];
    logic                 same_reg [0:ITERATIONS];
    logic                 valid_reg[0:ITERATIONS];

    logic signed [XW-1:0] x_next    [0:ITERATIONS];
    logic signed [XW-1:0] y_next    [0:ITERATIONS];
    acc_t                 acc_next  [0:ITERATIONS];
    logic                 hold_next [0:ITERATIONS];
    logic                 same_next [0:ITERATIONS];
    logic                 valid_in  [0:ITERATIONS];
    logic                 stage_ready[0:ITERATIONS];

    logic [ANGLE_WIDTH-1:0] bearing_reg;
    logic [ANGLE_WIDTH-1:0] bearing_next;
    logic                   same_out_reg;
    logic                   out_valid_reg;
    logic                   out_ready;
    acc_t                   rounded;

    logic [COORD_WIDTH-1:0]       from_x;
    logic [COORD_WIDTH-1:0]       from_y;
    logic [COORD_WIDTH-1:0]       to_x;
    logic [COORD_WIDTH-1:0]       to_y;
    logic signed [COORD_WIDTH:0]  dx;
    logic signed [COORD_WIDTH:0]  dy;
    logic signed [XW-1:0]         dx_ext;
    logic signed [XW-1:0]         dy_ext;

    // ready chain
    assign out_ready = !out_valid_reg || m_axis_tready;

    generate
        for (genvar k = 0; k <= ITERATIONS; k++)
        begin : g_ready
            if (k == ITERATIONS)
            begin : g_last
                assign stage_ready[k] = !valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            end
            if (k == 0)
            begin : g_vin0
                assign valid_in[k] = s_axis_tvalid;
            end
            else
            begin : g_vin
                assign valid_in[k] = valid_reg[k-1];
            end
        end
    endgenerate

    assign s_axis_tready = stage_ready[0];

    // difference vector and quadrant setup
    always_comb
    begin
        from_x = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
        from_y = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
        to_x   = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
        to_y   = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
        dx = $signed({to_x[COORD_WIDTH-1], to_x}) - $signed({from_x[COORD_WIDTH-1], from_x});
        dy = $signed({to_y[COORD_WIDTH-1], to_y}) - $signed({from_y[COORD_WIDTH-1], from_y});
        dx_ext = XW'(dx);
        dy_ext = XW'(dy);
        same_next[0] = 1'b0;
        hold_next[0] = 1'b1;
        x_next[0]    = dx_ext;
        y_next[0]    = dy_ext;
        if (dx == '0 && dy == '0)
        begin
            same_next[0] = 1'b1;
            acc_next[0]  = TURN_ZERO;
        end
        else if (dy == '0)
        begin
            acc_next[0] = dx[COORD_WIDTH] ? TURN_HALF : TURN_ZERO;
        end
        else if (dx == '0)
        begin
            acc_next[0] = dy[COORD_WIDTH] ? TURN_3QUART : TURN_QUARTER;
        end
        else if (dx[COORD_WIDTH])
        begin
            hold_next[0] = 1'b0;
            x_next[0]    = -dx_ext;
            y_next[0]    = -dy_ext;
            acc_next[0]  = TURN_HALF;
        end
        else
        begin
            hold_next[0] = 1'b0;
            acc_next[0]  = TURN_ZERO;
        end
    end

    // one micro-rotation per stage
    generate
        for (genvar i = 0; i < ITERATIONS; i++)
        begin : g_rot
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            always_comb
            begin
                hold_next[i+1] = hold_reg[i];
                same_next[i+1] = same_reg[i];
                if (!y_reg[i][XW-1])
                begin
                    x_next[i+1] = x_reg[i] + ys;
                    y_next[i+1] = y_reg[i] - xs;
                    acc_next[i+1] = hold_reg[i] ? acc_reg[i] : acc_reg[i] + ATAN_TURNS[i];
                end
                else
                begin
                    x_next[i+1] = x_reg[i] - ys;
                    y_next[i+1] = y_reg[i] + xs;
                    acc_next[i+1] = hold_reg[i] ? acc_reg[i] : acc_reg[i] - ATAN_TURNS[i];
                end
            end
        end
    endgenerate

    // stage registers
    generate
        for (genvar k = 0; k <= ITERATIONS; k++)
        begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && valid_in[k])
                begin
                    x_reg[k]    <= x_next[k];
                    y_reg[k]    <= y_next[k];
                    acc_reg[k]  <= acc_next[k];
                    hold_reg[k] <= hold_next[k];
                    same_reg[k] <= same_next[k];
                end
            end
        end
    endgenerate

    // rounding to the output angle width
    always_comb
    begin
        rounded      = acc_reg[ITERATIONS] + ROUND_ADD;
        bearing_next = rounded[ACC_WIDTH-1 -: ANGLE_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= valid_reg[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && valid_reg[ITERATIONS])
        begin
            bearing_reg  <= bearing_next;
            same_out_reg <= same_reg[ITERATIONS];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(bearing_reg);
    assign m_axis_tuser  = same_out_reg;

    // coincident points always come out as angle zero
    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("same_point item with nonzero bearing");

    // an accepted item lands in the first stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted item not captured");

    // last stage keeps its item while the output register is blocked
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ITERATIONS] && !out_ready) |=>
            (valid_reg[ITERATIONS] && $stable(acc_reg[ITERATIONS])))
        else $error("last stage lost its item during a stall");

endmodule
